>>> rtl/segment_intersection_point_assert.svh
// ----------------------------------------------------------------------------
// Segment intersection point: assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_POINT_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_ASSERT_SVH
`ifndef SYNTHESIS
`define SIP_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("segment_intersection_point: assertion failed");
`define SIP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("segment_intersection_point: assertion failed");
`else
`define SIP_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define SIP_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

>>> rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection point package
// Angle format, CORDIC arctangent table and fixed scaling constants.
// ----------------------------------------------------------------------------
package sip_pkg;

   typedef logic [31:0] atan_type;

   localparam int HEAD_BITS       = 16;
   localparam int ANGLE_BITS      = 34;
   localparam int ATAN_COUNT      = 32;
   localparam int CORDIC_PRESCALE = 14;
   localparam int SQRT_PRESHIFT   = 16;
   localparam int DIST_SHIFT      = 8;

   localparam logic signed [ANGLE_BITS-1:0] QUARTER_TURN = 34'sh0_4000_0000;
   localparam logic signed [ANGLE_BITS-1:0] HEAD_ROUND   = 34'sh0_0000_8000;

   // arctan(2^-i), 2^31 = pi
   localparam atan_type ATAN_TAB [ATAN_COUNT] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

endpackage

>>> rtl/sip_if.sv
// ----------------------------------------------------------------------------
// Segment intersection point channels
// Valid/ready channels for segment pairs and crossing results.
// ----------------------------------------------------------------------------
interface sip_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] ax;
   logic signed [COORD_BITS-1:0] ay;
   logic signed [COORD_BITS-1:0] bx;
   logic signed [COORD_BITS-1:0] by;
   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic signed [COORD_BITS-1:0] dx;
   logic signed [COORD_BITS-1:0] dy;

   modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
   modport sink (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

interface sip_rsp_if #(parameter int COORD_BITS = 16);
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic signed [COORD_BITS-1:0]         ix;
   logic signed [COORD_BITS-1:0]         iy;
   logic signed [sip_pkg::HEAD_BITS-1:0] heading;
   logic [COORD_BITS:0]                  distance;

   modport source (output valid, hit, ix, iy, heading, distance, input ready);
   modport sink (input valid, hit, ix, iy, heading, distance, output ready);
endinterface

>>> rtl/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// Segment intersection point
// Proper-crossing test of two segments with crossing point, distance, heading.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one segment pair (A to B, C to D) per transaction, signed
//   Q12.4 endpoints. rsp_chan returns one result per transaction, in order:
//   hit, crossing point ix/iy, distance from A (unsigned Q13.4) and heading
//   of AB (32768 = pi). With no proper crossing every field is zero.
//   A result reaches rsp_chan.valid through the longest of three branches: the
//   distance branch (square-root cells, split multiply, divider cells), the
//   crossing-point branch and the CORDIC chain; the shorter branches are
//   delayed to match it.
//   Throughput: one transaction per cycle unless rsp_chan stalls; the divider
//   and square-root rows retire one bit per cell; cells take new data every cycle.
//   Stall: the whole pipeline holds while the output register waits on
//   rsp_chan.ready; req_chan.ready follows.
//   Reset: synchronous; clears all valid bits, no result in flight survives.
// ----------------------------------------------------------------------------
`include "segment_intersection_point_assert.svh"

module segment_intersection_point #(
   parameter int COORD_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input logic clock,
   input logic reset,
   sip_req_if.sink   req_chan,
   sip_rsp_if.source rsp_chan
);
   import sip_pkg::*;

   localparam int W    = COORD_BITS;
   localparam int DW   = W + 1;
   localparam int PW   = 2 * W + 2;
   localparam int CW   = 2 * W + 3;
   localparam int NW   = 2 * W + 2;
   localparam int L2W  = 2 * W + 1;
   localparam int RW   = (L2W + SQRT_PRESHIFT + 1) / 2;
   localparam int SQW  = 2 * RW;
   localparam int LOB  = RW / 2;
   localparam int HIB  = RW - LOB;
   localparam int QL   = W;
   localparam int LRW  = W + NW + 2;
   localparam int QD   = W + 1;
   localparam int DRW  = RW + NW + 1;
   localparam int XW   = W + 17;
   localparam int NCOR = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;
   localparam int LC   = NCOR;
   localparam int LL   = QL + 2;
   localparam int LD   = RW + 2 + QD;
   localparam int LAT0 = (LC > LL) ? LC : LL;
   localparam int LAT  = (LAT0 > LD) ? LAT0 : LD;
   localparam int PIPE = LAT + 3;

   // ---------------- handshake ----------------
   logic            adv;
   logic [PIPE-1:0] vld_ff;
   logic            rsp_valid_ff;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE-2:0], req_chan.valid};
         rsp_valid_ff <= vld_ff[PIPE-1];
      end
   end

   // ---------------- stage 1: differences ----------------
   logic signed [DW-1:0] ex_ff, ey_ff, fx_ff, fy_ff;
   logic signed [DW-1:0] acx_ff, acy_ff, adx_ff, ady_ff;
   logic signed [DW-1:0] cax_ff, cay_ff, bcx_ff, bcy_ff;
   logic signed [W-1:0]  ax_s1_ff, ay_s1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_ff    <= DW'(req_chan.bx) - DW'(req_chan.ax);
         ey_ff    <= DW'(req_chan.by) - DW'(req_chan.ay);
         fx_ff    <= DW'(req_chan.dx) - DW'(req_chan.cx);
         fy_ff    <= DW'(req_chan.dy) - DW'(req_chan.cy);
         acx_ff   <= DW'(req_chan.cx) - DW'(req_chan.ax);
         acy_ff   <= DW'(req_chan.cy) - DW'(req_chan.ay);
         adx_ff   <= DW'(req_chan.dx) - DW'(req_chan.ax);
         ady_ff   <= DW'(req_chan.dy) - DW'(req_chan.ay);
         cax_ff   <= DW'(req_chan.ax) - DW'(req_chan.cx);
         cay_ff   <= DW'(req_chan.ay) - DW'(req_chan.cy);
         bcx_ff   <= DW'(req_chan.bx) - DW'(req_chan.cx);
         bcy_ff   <= DW'(req_chan.by) - DW'(req_chan.cy);
         ax_s1_ff <= req_chan.ax;
         ay_s1_ff <= req_chan.ay;
      end
   end

   // ---------------- stage 2: products ----------------
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff, p8_ff;
   logic signed [PW-1:0] sx_ff, sy_ff;
   logic signed [DW-1:0] ex_s2_ff, ey_s2_ff;
   logic signed [W-1:0]  ax_s2_ff, ay_s2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff    <= ex_ff * acy_ff;
         p2_ff    <= ey_ff * acx_ff;
         p3_ff    <= ex_ff * ady_ff;
         p4_ff    <= ey_ff * adx_ff;
         p5_ff    <= fx_ff * cay_ff;
         p6_ff    <= fy_ff * cax_ff;
         p7_ff    <= fx_ff * bcy_ff;
         p8_ff    <= fy_ff * bcx_ff;
         sx_ff    <= ex_ff * ex_ff;
         sy_ff    <= ey_ff * ey_ff;
         ex_s2_ff <= ex_ff;
         ey_s2_ff <= ey_ff;
         ax_s2_ff <= ax_s1_ff;
         ay_s2_ff <= ay_s1_ff;
      end
   end

   // ---------------- stage 3: sides, ratio terms, length ----------------
   logic signed [CW-1:0] c_ab_c, c_ab_d, c_cd_a, c_cd_b;
   logic [NW-1:0]        mag_a, mag_b;
   logic                 hit_in;
   logic                 hit_s3_ff;
   logic [NW-1:0]        num_s3_ff, den_s3_ff;
   logic [L2W-1:0]       len2_s3_ff;
   logic signed [DW-1:0] ex_s3_ff, ey_s3_ff;
   logic signed [W-1:0]  ax_s3_ff, ay_s3_ff;

   assign c_ab_c = CW'(p1_ff) - CW'(p2_ff);
   assign c_ab_d = CW'(p3_ff) - CW'(p4_ff);
   assign c_cd_a = CW'(p5_ff) - CW'(p6_ff);
   assign c_cd_b = CW'(p7_ff) - CW'(p8_ff);
   assign mag_a  = c_cd_a[CW-1] ? NW'(-c_cd_a) : NW'(c_cd_a);
   assign mag_b  = c_cd_b[CW-1] ? NW'(-c_cd_b) : NW'(c_cd_b);

   // strict opposite sides: both nonzero and signs differ
   assign hit_in = (c_ab_c != '0) && (c_ab_d != '0) && (c_ab_c[CW-1] != c_ab_d[CW-1]) &&
                   (c_cd_a != '0) && (c_cd_b != '0) && (c_cd_a[CW-1] != c_cd_b[CW-1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_s3_ff  <= hit_in;
         num_s3_ff  <= mag_a;
         den_s3_ff  <= mag_a + mag_b;
         len2_s3_ff <= L2W'(sx_ff) + L2W'(sy_ff);
         ex_s3_ff   <= ex_s2_ff;
         ey_s3_ff   <= ey_s2_ff;
         ax_s3_ff   <= ax_s2_ff;
         ay_s3_ff   <= ay_s2_ff;
      end
   end

   // ---------------- crossing point branch ----------------
   logic [W-1:0]      magx, magy;
   logic [W+NW-1:0]   lx_prod_ff, ly_prod_ff;
   logic [NW-1:0]     lm_den_ff;
   logic [LRW-1:0]    lx_n_ff, ly_n_ff;
   logic [NW-1:0]     la_den_ff;
   logic [LRW-1:0]    lx_rem [QL+1];
   logic [LRW-1:0]    ly_rem [QL+1];
   logic [NW-1:0]     lx_div [QL+1];
   logic [NW-1:0]     ly_div [QL+1];
   logic [QL-1:0]     lx_quot [QL+1];
   logic [QL-1:0]     ly_quot [QL+1];

   assign magx = ex_s3_ff[DW-1] ? W'(-ex_s3_ff) : W'(ex_s3_ff);
   assign magy = ey_s3_ff[DW-1] ? W'(-ey_s3_ff) : W'(ey_s3_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         lx_prod_ff <= magx * num_s3_ff;
         ly_prod_ff <= magy * num_s3_ff;
         lm_den_ff  <= den_s3_ff;
         // half-away rounding: (2*mag*num + den) / (2*den)
         lx_n_ff    <= LRW'({lx_prod_ff, 1'b0}) + LRW'(lm_den_ff);
         ly_n_ff    <= LRW'({ly_prod_ff, 1'b0}) + LRW'(lm_den_ff);
         la_den_ff  <= lm_den_ff;
      end
   end

   assign lx_rem[0]  = lx_n_ff;
   assign ly_rem[0]  = ly_n_ff;
   assign lx_div[0]  = la_den_ff;
   assign ly_div[0]  = la_den_ff;
   assign lx_quot[0] = '0;
   assign ly_quot[0] = '0;

   generate
      for (genvar k = 0; k < QL; k++) begin : g_lerp
         sip_div_cell #(
            .REM_BITS(LRW), .DIV_BITS(NW), .QUOT_BITS(QL), .SHIFT(1 + QL - 1 - k)
         ) u_div_x (
            .clock(clock), .enable(adv),
            .src_rem(lx_rem[k]), .src_div(lx_div[k]), .src_quot(lx_quot[k]),
            .dst_rem(lx_rem[k+1]), .dst_div(lx_div[k+1]), .dst_quot(lx_quot[k+1])
         );
         sip_div_cell #(
            .REM_BITS(LRW), .DIV_BITS(NW), .QUOT_BITS(QL), .SHIFT(1 + QL - 1 - k)
         ) u_div_y (
            .clock(clock), .enable(adv),
            .src_rem(ly_rem[k]), .src_div(ly_div[k]), .src_quot(ly_quot[k]),
            .dst_rem(ly_rem[k+1]), .dst_div(ly_div[k+1]), .dst_quot(ly_quot[k+1])
         );
      end
   endgenerate

   logic [2*W+1:0]      base_src, base_dst;
   logic signed [W-1:0] ax_l, ay_l;
   logic                negx_l, negy_l;
   logic [W-1:0]        ix_l, iy_l;
   logic [2*W-1:0]      pt_dst;

   assign base_src = {ex_s3_ff[DW-1], ey_s3_ff[DW-1], ax_s3_ff, ay_s3_ff};

   sip_delay #(.WIDTH(2 * W + 2), .DEPTH(LL)) u_base_dly (
      .clock(clock), .enable(adv), .src_data(base_src), .dst_data(base_dst)
   );

   assign negx_l = base_dst[2*W+1];
   assign negy_l = base_dst[2*W];
   assign ax_l   = base_dst[2*W-1:W];
   assign ay_l   = base_dst[W-1:0];
   assign ix_l   = negx_l ? ax_l - lx_quot[QL] : ax_l + lx_quot[QL];
   assign iy_l   = negy_l ? ay_l - ly_quot[QL] : ay_l + ly_quot[QL];

   sip_delay #(.WIDTH(2 * W), .DEPTH(LAT - LL)) u_pt_dly (
      .clock(clock), .enable(adv), .src_data({ix_l, iy_l}), .dst_data(pt_dst)
   );

   // ---------------- distance branch ----------------
   logic [SQW-1:0]  sq_rad  [RW+1];
   logic [SQW-1:0]  sq_root [RW+1];
   logic [2*NW-1:0] nd_dst;
   logic [RW-1:0]   lq;
   logic [LOB+NW-1:0] dp_lo_ff;
   logic [HIB+NW-1:0] dp_hi_ff;
   logic [NW-1:0]   dp_den_ff;
   logic [DRW-1:0]  dn_ff;
   logic [NW-1:0]   dn_den_ff;
   logic [DRW-1:0]  d_rem  [QD+1];
   logic [NW-1:0]   d_div  [QD+1];
   logic [QD-1:0]   d_quot [QD+1];
   logic [QD-1:0]   dist_dst;

   assign sq_rad[0]  = SQW'({len2_s3_ff, {SQRT_PRESHIFT{1'b0}}});
   assign sq_root[0] = '0;

   generate
      for (genvar k = 0; k < RW; k++) begin : g_sqrt
         sip_sqrt_cell #(.BITS(SQW), .STEP(RW - 1 - k)) u_sqrt (
            .clock(clock), .enable(adv),
            .src_rad(sq_rad[k]), .src_root(sq_root[k]),
            .dst_rad(sq_rad[k+1]), .dst_root(sq_root[k+1])
         );
      end
   endgenerate

   sip_delay #(.WIDTH(2 * NW), .DEPTH(RW)) u_nd_dly (
      .clock(clock), .enable(adv), .src_data({num_s3_ff, den_s3_ff}), .dst_data(nd_dst)
   );

   assign lq = sq_root[RW][RW-1:0];

   // split |AB| * num into two narrow partial products, then add the rounding term
   always_ff @(posedge clock) begin
      if (adv) begin
         dp_lo_ff  <= lq[LOB-1:0] * nd_dst[2*NW-1:NW];
         dp_hi_ff  <= lq[RW-1:LOB] * nd_dst[2*NW-1:NW];
         dp_den_ff <= nd_dst[NW-1:0];
         dn_ff     <= (DRW'(dp_hi_ff) << LOB) + DRW'(dp_lo_ff) +
                      (DRW'(dp_den_ff) << (DIST_SHIFT - 1));
         dn_den_ff <= dp_den_ff;
      end
   end

   assign d_rem[0]  = dn_ff;
   assign d_div[0]  = dn_den_ff;
   assign d_quot[0] = '0;

   generate
      for (genvar k = 0; k < QD; k++) begin : g_dist
         sip_div_cell #(
            .REM_BITS(DRW), .DIV_BITS(NW), .QUOT_BITS(QD),
            .SHIFT(DIST_SHIFT + QD - 1 - k)
         ) u_div_d (
            .clock(clock), .enable(adv),
            .src_rem(d_rem[k]), .src_div(d_div[k]), .src_quot(d_quot[k]),
            .dst_rem(d_rem[k+1]), .dst_div(d_div[k+1]), .dst_quot(d_quot[k+1])
         );
      end
   endgenerate

   // quotient cannot pass the field range, so no clamp stage
   sip_delay #(.WIDTH(QD), .DEPTH(LAT - LD)) u_dist_dly (
      .clock(clock), .enable(adv), .src_data(d_quot[QD]), .dst_data(dist_dst)
   );

   // ---------------- heading branch ----------------
   logic signed [XW-1:0]         x_pre, y_pre;
   logic signed [XW-1:0]         x_rot, y_rot;
   logic signed [ANGLE_BITS-1:0] z_rot;
   logic signed [XW-1:0]         cx_pipe [NCOR+1];
   logic signed [XW-1:0]         cy_pipe [NCOR+1];
   logic signed [ANGLE_BITS-1:0] cz_pipe [NCOR+1];
   logic signed [ANGLE_BITS-1:0] z_round;
   logic [HEAD_BITS-1:0]         head_dst;

   assign x_pre = XW'(ex_s3_ff) <<< CORDIC_PRESCALE;
   assign y_pre = XW'(ey_s3_ff) <<< CORDIC_PRESCALE;

   // fold the left half-plane onto the right one
   always_comb begin
      x_rot = x_pre;
      y_rot = y_pre;
      z_rot = '0;
      if (x_pre[XW-1]) begin
         if (!y_pre[XW-1]) begin
            x_rot = y_pre;
            y_rot = -x_pre;
            z_rot = QUARTER_TURN;
         end else begin
            x_rot = -y_pre;
            y_rot = x_pre;
            z_rot = -QUARTER_TURN;
         end
      end
   end

   assign cx_pipe[0] = x_rot;
   assign cy_pipe[0] = y_rot;
   assign cz_pipe[0] = z_rot;

   generate
      for (genvar k = 0; k < NCOR; k++) begin : g_cordic
         sip_cordic_cell #(.XW(XW), .IDX(k)) u_cordic (
            .clock(clock), .enable(adv),
            .src_x(cx_pipe[k]), .src_y(cy_pipe[k]), .src_z(cz_pipe[k]),
            .dst_x(cx_pipe[k+1]), .dst_y(cy_pipe[k+1]), .dst_z(cz_pipe[k+1])
         );
      end
   endgenerate

   assign z_round = cz_pipe[NCOR] + HEAD_ROUND;

   sip_delay #(.WIDTH(HEAD_BITS), .DEPTH(LAT - LC)) u_head_dly (
      .clock(clock), .enable(adv), .src_data(z_round[HEAD_BITS+15:16]),
      .dst_data(head_dst)
   );

   // ---------------- hit alignment and output register ----------------
   logic                 hit_dst;
   logic                 rsp_hit_ff;
   logic [W-1:0]         rsp_ix_ff, rsp_iy_ff;
   logic [HEAD_BITS-1:0] rsp_head_ff;
   logic [QD-1:0]        rsp_dist_ff;

   sip_delay #(.WIDTH(1), .DEPTH(LAT)) u_hit_dly (
      .clock(clock), .enable(adv), .src_data(hit_s3_ff), .dst_data(hit_dst)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff  <= hit_dst;
         rsp_ix_ff   <= hit_dst ? pt_dst[2*W-1:W] : '0;
         rsp_iy_ff   <= hit_dst ? pt_dst[W-1:0] : '0;
         rsp_head_ff <= hit_dst ? head_dst : '0;
         rsp_dist_ff <= hit_dst ? dist_dst : '0;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.ix       = rsp_ix_ff;
   assign rsp_chan.iy       = rsp_iy_ff;
   assign rsp_chan.heading  = rsp_head_ff;
   assign rsp_chan.distance = rsp_dist_ff;

   // ---------------- assertions ----------------
   `SIP_ASSERT_IMPLY(a_div_operands, clock, reset, vld_ff[2] && hit_s3_ff, (num_s3_ff != '0) && (den_s3_ff > num_s3_ff))
   `SIP_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, (rsp_ix_ff == '0) && (rsp_iy_ff == '0) && (rsp_head_ff == '0) && (rsp_dist_ff == '0))
   `SIP_ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_valid_ff && !rsp_chan.ready, vld_ff == $past(vld_ff))
   `SIP_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid_ff && (vld_ff == '0))

endmodule

>>> rtl/sip_delay.sv
// ----------------------------------------------------------------------------
// Segment intersection point delay line
// Stallable shift line that aligns a value with another datapath branch.
// ----------------------------------------------------------------------------
module sip_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] src_data,
   output logic [WIDTH-1:0] dst_data
);

   generate
      if (DEPTH == 0) begin : g_direct
         assign dst_data = src_data;
      end else begin : g_line
         logic [WIDTH-1:0] tap_ff [DEPTH];

         always_ff @(posedge clock) begin
            if (enable) begin
               tap_ff[0] <= src_data;
               for (int i = 1; i < DEPTH; i++) begin
                  tap_ff[i] <= tap_ff[i-1];
               end
            end
         end

         assign dst_data = tap_ff[DEPTH-1];
      end
   endgenerate

endmodule

>>> rtl/sip_div_cell.sv
// ----------------------------------------------------------------------------
// Segment intersection point divider cell
// One restoring step: retires one quotient bit and hands on the remainder.
// ----------------------------------------------------------------------------
module sip_div_cell #(
   parameter int REM_BITS  = 52,
   parameter int DIV_BITS  = 34,
   parameter int QUOT_BITS = 16,
   parameter int SHIFT     = 1
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [REM_BITS-1:0]  src_rem,
   input  logic [DIV_BITS-1:0]  src_div,
   input  logic [QUOT_BITS-1:0] src_quot,
   output logic [REM_BITS-1:0]  dst_rem,
   output logic [DIV_BITS-1:0]  dst_div,
   output logic [QUOT_BITS-1:0] dst_quot
);

   logic [REM_BITS:0]    trial;
   logic                 take;
   logic [REM_BITS-1:0]  rem_in;
   logic [QUOT_BITS-1:0] quot_in;
   logic [REM_BITS-1:0]  rem_ff;
   logic [DIV_BITS-1:0]  div_ff;
   logic [QUOT_BITS-1:0] quot_ff;

   assign trial   = {1'b0, src_rem} - ({1'b0, REM_BITS'(src_div)} << SHIFT);
   assign take    = !trial[REM_BITS];
   assign rem_in  = take ? trial[REM_BITS-1:0] : src_rem;
   assign quot_in = {src_quot[QUOT_BITS-2:0], take};

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         div_ff  <= src_div;
         quot_ff <= quot_in;
      end
   end

   assign dst_rem  = rem_ff;
   assign dst_div  = div_ff;
   assign dst_quot = quot_ff;

endmodule

>>> rtl/sip_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Segment intersection point square-root cell
// One digit-by-digit step of the integer square root.
// ----------------------------------------------------------------------------
module sip_sqrt_cell #(
   parameter int BITS = 50,
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            enable,
   input  logic [BITS-1:0] src_rad,
   input  logic [BITS-1:0] src_root,
   output logic [BITS-1:0] dst_rad,
   output logic [BITS-1:0] dst_root
);

   localparam logic [BITS-1:0] BIT_VAL = BITS'(1) << (2 * STEP);

   logic [BITS:0]   trial;
   logic            take;
   logic [BITS-1:0] rad_in;
   logic [BITS-1:0] root_in;
   logic [BITS-1:0] rad_ff;
   logic [BITS-1:0] root_ff;

   assign trial   = {1'b0, src_rad} - {1'b0, src_root + BIT_VAL};
   assign take    = !trial[BITS];
   assign rad_in  = take ? trial[BITS-1:0] : src_rad;
   assign root_in = take ? (src_root >> 1) + BIT_VAL : src_root >> 1;

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
      end
   end

   assign dst_rad  = rad_ff;
   assign dst_root = root_ff;

endmodule

>>> rtl/sip_cordic_cell.sv
// ----------------------------------------------------------------------------
// Segment intersection point CORDIC cell
// One vectoring micro-rotation that drives y toward zero.
// ----------------------------------------------------------------------------
module sip_cordic_cell #(
   parameter int XW  = 33,
   parameter int IDX = 0
) (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [XW-1:0]                 src_x,
   input  logic signed [XW-1:0]                 src_y,
   input  logic signed [sip_pkg::ANGLE_BITS-1:0] src_z,
   output logic signed [XW-1:0]                 dst_x,
   output logic signed [XW-1:0]                 dst_y,
   output logic signed [sip_pkg::ANGLE_BITS-1:0] dst_z
);
   import sip_pkg::*;

   logic signed [ANGLE_BITS-1:0] step_ang;
   logic signed [XW-1:0]         x_sh;
   logic signed [XW-1:0]         y_sh;
   logic signed [XW-1:0]         x_in;
   logic signed [XW-1:0]         y_in;
   logic signed [ANGLE_BITS-1:0] z_in;
   logic signed [XW-1:0]         x_ff;
   logic signed [XW-1:0]         y_ff;
   logic signed [ANGLE_BITS-1:0] z_ff;

   assign step_ang = ANGLE_BITS'(signed'({1'b0, ATAN_TAB[IDX]}));
   assign x_sh     = src_x >>> IDX;
   assign y_sh     = src_y >>> IDX;

   always_comb begin
      if (!src_y[XW-1]) begin
         x_in = src_x + y_sh;
         y_in = src_y - x_sh;
         z_in = src_z + step_ang;
      end else begin
         x_in = src_x - y_sh;
         y_in = src_y + x_sh;
         z_in = src_z - step_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dst_x = x_ff;
   assign dst_y = y_ff;
   assign dst_z = z_ff;

endmodule

>>> verif/sip_crossing_checker.sv
// ----------------------------------------------------------------------------
// Segment intersection point: result checker
// Watches both channels, predicts each crossing result from the accepted
// segment pair and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sip_crossing_checker #(
   parameter int COORD_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic clock,
   input  logic reset,
   sip_req_if   req_mon,
   sip_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   result_count,
   output int   hit_count
);

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] ix;
      logic signed [COORD_BITS-1:0] iy;
      logic signed [15:0]           heading;
      logic [COORD_BITS:0]          distance;
   } crossing_type;

   crossing_type expected_crossings[$];

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint cordic_heading(input longint ex, input longint ey);
      longint x, y, z, t, xs, ys;
      int     stages;
      x = ex * 16384;
      y = ey * 16384;
      z = 0;
      stages = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
      // fold the left half-plane onto the right
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 64'sh4000_0000;
         end else begin
            t = x; x = -y; y = t; z = -64'sh4000_0000;
         end
      end
      for (int i = 0; i < stages; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + longint'(sip_pkg::ATAN_TAB[i]);
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(sip_pkg::ATAN_TAB[i]);
         end
      end
      return (z + 32768) >>> 16;
   endfunction

   function automatic longint interpolate(input longint a, input longint b,
                                          input longint unsigned num,
                                          input longint unsigned den);
      longint          e;
      longint unsigned mag, q;
      e = b - a;
      mag = (e < 0) ? -e : e;
      q = (2 * mag * num + den) / (2 * den);
      return (e < 0) ? a - longint'(q) : a + longint'(q);
   endfunction

   function automatic bit straddles(input longint p, input longint q);
      return (p > 0 && q < 0) || (p < 0 && q > 0);
   endfunction

   function automatic crossing_type predict_crossing(
         input longint ax, input longint ay, input longint bx, input longint by,
         input longint cx, input longint cy, input longint dx, input longint dy);
      crossing_type    res;
      longint          ex, ey, fx, fy, side_c, side_d, side_a, side_b;
      longint unsigned num, den, len, dist_q;
      res = '0;
      ex = bx - ax; ey = by - ay; fx = dx - cx; fy = dy - cy;
      side_c = ex * (cy - ay) - ey * (cx - ax);
      side_d = ex * (dy - ay) - ey * (dx - ax);
      side_a = fx * (ay - cy) - fy * (ax - cx);
      side_b = fx * (by - cy) - fy * (bx - cx);
      if (!straddles(side_c, side_d) || !straddles(side_a, side_b)) return res;
      num = (side_a < 0) ? -side_a : side_a;
      den = num + ((side_b < 0) ? -side_b : side_b);
      len = int_sqrt(longint'(ex * ex + ey * ey) << 16);
      dist_q = (2 * len * num + den * 256) / (den * 512);
      if (dist_q > 131071) dist_q = 131071;
      res.hit      = 1'b1;
      res.ix       = COORD_BITS'(interpolate(ax, bx, num, den));
      res.iy       = COORD_BITS'(interpolate(ay, by, num, den));
      res.heading  = 16'(cordic_heading(ex, ey));
      res.distance = (COORD_BITS + 1)'(dist_q);
      return res;
   endfunction

   assign pending_count = expected_crossings.size();

   always @(posedge clock) begin
      crossing_type want;
      if (reset) begin
         expected_crossings.delete();
         fail_count   <= 0;
         result_count <= 0;
         hit_count    <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_crossings.push_back(predict_crossing(
               req_mon.ax, req_mon.ay, req_mon.bx, req_mon.by,
               req_mon.cx, req_mon.cy, req_mon.dx, req_mon.dy));
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count <= result_count + 1;
            if (expected_crossings.size() == 0) begin
               $error("result transaction with nothing outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_crossings.pop_front();
               if (want.hit) hit_count <= hit_count + 1;
               if (want !== {rsp_mon.hit, rsp_mon.ix, rsp_mon.iy, rsp_mon.heading,
                             rsp_mon.distance}) begin
                  fail_count <= fail_count + 1;
                  if (want.hit !== rsp_mon.hit)
                     $error("hit: expected %0d, got %0d", want.hit, rsp_mon.hit);
                  if (want.ix !== rsp_mon.ix)
                     $error("ix: expected %0d, got %0d", want.ix, rsp_mon.ix);
                  if (want.iy !== rsp_mon.iy)
                     $error("iy: expected %0d, got %0d", want.iy, rsp_mon.iy);
                  if (want.heading !== rsp_mon.heading)
                     $error("heading: expected %0d, got %0d", want.heading,
                            rsp_mon.heading);
                  if (want.distance !== rsp_mon.distance)
                     $error("distance: expected %0d, got %0d", want.distance,
                            rsp_mon.distance);
               end
            end
         end
      end
   end

endmodule

>>> verif/segment_intersection_point_tb.sv
// ----------------------------------------------------------------------------
// Segment intersection point testbench
// Drives directed and random segment pairs through the valid/ready channel
// under varying back-pressure; a checker beside the block verifies results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_point_tb;

   localparam int COORD_BITS = 16;
   localparam int PHASE_ITEMS = 150;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef struct {
      coord_type ax, ay, bx, by, cx, cy, dx, dy;
   } seg_pair_type;

   logic clock;
   logic reset;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   fail_count, pending_count, result_count, hit_count;

   sip_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   sip_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_chan ();

   segment_intersection_point #(.COORD_BITS(COORD_BITS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   sip_crossing_checker #(.COORD_BITS(COORD_BITS)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .hit_count     (hit_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= !reset && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_pair(input seg_pair_type p);
      req_chan.valid <= 1'b1;
      req_chan.ax <= p.ax; req_chan.ay <= p.ay;
      req_chan.bx <= p.bx; req_chan.by <= p.by;
      req_chan.cx <= p.cx; req_chan.cy <= p.cy;
      req_chan.dx <= p.dx; req_chan.dy <= p.dy;
      do @(posedge clock); while (!req_chan.ready);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_coords(input int ax, ay, bx, by, cx, cy, dx, dy);
      seg_pair_type p;
      p.ax = coord_type'(ax); p.ay = coord_type'(ay);
      p.bx = coord_type'(bx); p.by = coord_type'(by);
      p.cx = coord_type'(cx); p.cy = coord_type'(cy);
      p.dx = coord_type'(dx); p.dy = coord_type'(dy);
      send_pair(p);
   endtask

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   // Segments through a shared point, so most pairs really cross.
   function automatic seg_pair_type crossing_pair();
      seg_pair_type p;
      int           px, py, sh;
      sh = $urandom_range(0, 10);
      px = int'($signed(16'($urandom)) >>> 1);
      py = int'($signed(16'($urandom)) >>> 1);
      p.ax = coord_type'(px + int'($signed(16'($urandom)) >>> (sh + 1)));
      p.ay = coord_type'(py + int'($signed(16'($urandom)) >>> (sh + 1)));
      p.cx = coord_type'(px + int'($signed(16'($urandom)) >>> (sh + 1)));
      p.cy = coord_type'(py + int'($signed(16'($urandom)) >>> (sh + 1)));
      p.bx = coord_type'(px + ((px - p.ax) >>> $urandom_range(0, 2)));
      p.by = coord_type'(py + ((py - p.ay) >>> $urandom_range(0, 2)));
      p.dx = coord_type'(px + ((px - p.cx) >>> $urandom_range(0, 2)));
      p.dy = coord_type'(py + ((py - p.cy) >>> $urandom_range(0, 2)));
      return p;
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type p;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 65) return crossing_pair();
      p.ax = any_coord(); p.ay = any_coord(); p.bx = any_coord(); p.by = any_coord();
      p.cx = any_coord(); p.cy = any_coord(); p.dx = any_coord(); p.dy = any_coord();
      if (pick < 85) return p;
      case ($urandom_range(0, 3))
         0: begin  // C on line AB
            p.cx = coord_type'(p.ax + (p.bx - p.ax) / 2);
            p.cy = coord_type'(p.ay + (p.by - p.ay) / 2);
            p.bx = coord_type'(p.ax + 2 * (p.cx - p.ax));
            p.by = coord_type'(p.ay + 2 * (p.cy - p.ay));
         end
         1: begin  // parallel
            p.dx = p.cx + (p.bx - p.ax); p.dy = p.cy + (p.by - p.ay);
         end
         2: begin  // degenerate first segment
            p.bx = p.ax; p.by = p.ay;
         end
         default: begin  // shared end point
            p.cx = p.bx; p.cy = p.by;
         end
      endcase
      return p;
   endfunction

   initial begin
      reset          <= 1'b1;
      tx_idle_pct    = 0;
      rx_idle_pct    = 0;
      req_chan.valid <= 1'b0;
      req_chan.ax <= '0; req_chan.ay <= '0; req_chan.bx <= '0; req_chan.by <= '0;
      req_chan.cx <= '0; req_chan.cy <= '0; req_chan.dx <= '0; req_chan.dy <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, headings on every axis, touching and degenerate cases
      send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_coords(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
      send_coords(32767, 0, -32768, 0, 0, -32768, 0, 32767);
      send_coords(-32768, 0, 32767, 0, 0, 32767, 0, -32768);
      send_coords(0, -32768, 0, 32767, -100, 5, 100, 5);
      send_coords(0, 32767, 0, -32768, 100, -7, -100, -7);
      send_coords(-50, 30, 50, -30, -50, -30, 50, 30);
      send_coords(0, 0, 1, 1, 0, 1, 1, 0);
      send_coords(0, 0, -1, 1, -1, 0, 0, 1);
      send_coords(0, 0, 3, 0, 1, -1, 2, 1);
      send_coords(0, 0, 100, 0, 50, 0, 50, 100);
      send_coords(0, 0, 100, 0, 100, 0, 200, 50);
      send_coords(0, 0, 100, 0, 20, 0, 80, 0);
      send_coords(0, 0, 100, 0, 0, 10, 100, 10);
      send_coords(5, 5, 5, 5, 0, 0, 10, 10);
      send_coords(0, 0, 0, 0, 0, 0, 0, 0);
      send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
      send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      send_coords(-1000, 0, 1000, 1, 0, -1000, 1, 1000);

      tx_idle_pct = 21; rx_idle_pct = 87;
      repeat (PHASE_ITEMS) send_pair(random_pair());

      // hold off until the pipeline drains completely
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);

      tx_idle_pct = 87; rx_idle_pct = 21;
      repeat (PHASE_ITEMS) send_pair(random_pair());
      tx_idle_pct = 0; rx_idle_pct = 0;
      repeat (PHASE_ITEMS) send_pair(random_pair());
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Checked %0d results, %0d of them proper crossings,", result_count,
               hit_count);
      $display("under sender and receiver stalls and back-to-back streaming.");
      if (fail_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
